// ----- rtl/core/chist_pkg.sv -----
// Shared types, widths, reset values and register codes for the clamped histogram accumulator.
// No dependencies; every other file in rtl/core imports this package.
package chist_pkg;

    localparam int NumBinsDefault = 64;

    localparam int SampleW = 32;
    localparam int SelW    = 6;
    localparam int IdxW    = 6;
    localparam int HitsW   = 32;
    localparam int SumW    = 64;
    localparam int UsedW   = 7;

    localparam logic signed [SampleW-1:0] RangeMinReset   = 32'sd0;
    localparam logic signed [SampleW-1:0] RangeMaxReset   = 32'sd6553600;
    localparam logic        [31:0]        BinsPerUnitReset = 32'd41943;
    localparam logic        [UsedW-1:0]   BinsUsedReset   = 7'd64;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] RegRangeMin    = 2'd0;
    localparam logic [1:0] RegRangeMax    = 2'd1;
    localparam logic [1:0] RegBinsPerUnit = 2'd2;
    localparam logic [1:0] RegBinsUsed    = 2'd3;

    // Request kinds carried in tuser.
    localparam logic ReqAdd  = 1'b0;
    localparam logic ReqRead = 1'b1;

    typedef struct packed {
        logic signed [SampleW-1:0] range_min;
        logic signed [SampleW-1:0] range_max;
        logic        [31:0]        bins_per_unit;
        logic        [UsedW-1:0]   bins_used;
    } t_cfg;

    // One request travelling down the pipeline.
    typedef struct packed {
        logic                      valid;
        logic                      is_add;
        logic                      zero;
        logic        [SelW-1:0]    sel;
        logic signed [SampleW-1:0] sample;
    } t_item;

    typedef struct packed {
        logic        [SampleW-1:0] samples_seen;
        logic signed [SumW-1:0]    grand_total;
        logic signed [SampleW-1:0] high_seen;
        logic signed [SampleW-1:0] low_seen;
        logic signed [SumW-1:0]    bin_total;
        logic        [HitsW-1:0]   bin_hits;
        logic        [IdxW-1:0]    bin_index;
    } t_result;

endpackage

// ----- rtl/core/clamped_histogram_accumulator_top.sv -----
// A result is offered after the capture, offset, scale, bin update and result registers.
// Throughput: one transaction per cycle unless a result is held; bins forward back to back.
// The whole pipeline moves together, so input ready drops while a result is held.
// Reset is synchronous; afterwards the bin memory clears entry by entry with input
// ready low. Configuration writes are taken at any time. Depends on chist_pkg and children.
module clamped_histogram_accumulator_top
    import chist_pkg::*;
#(
    parameter int NUM_BINS = NumBinsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Request stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [39:0]  i_s_tdata,  // sample [31:0], bin_select [37:32], zero [39:38]
    input  logic         i_s_tuser,  // req_type [0]
    // Result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // bin_index [5:0], bin_hits [37:6], bin_total [101:38], low_seen [133:102],
    // high_seen [165:134], grand_total [229:166], samples_seen [261:230], zero [263:262]
    output logic [263:0] o_m_tdata
);

    localparam int BinW = $clog2(NUM_BINS);

    t_cfg                   w_cfg;
    logic                   w_adv;
    logic                   w_clearing;
    t_item                  w_item;
    logic [BinW-1:0]        w_bin;
    logic [HitsW-1:0]       w_rd_hits;
    logic signed [SumW-1:0] w_rd_sum;
    logic                   w_wr_en;
    logic [BinW-1:0]        w_wr_addr;
    logic [HitsW-1:0]       w_wr_hits;
    logic signed [SumW-1:0] w_wr_sum;
    t_result                w_result;

    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv && !w_clearing;
    assign o_m_tdata  = {2'b00, w_result};

    chist_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    chist_bin #(.NUM_BINS(NUM_BINS)) u_bin (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (i_s_tvalid && o_s_tready),
        .i_req_type   (i_s_tuser),
        .i_sample     (i_s_tdata[31:0]),
        .i_bin_select (i_s_tdata[37:32]),
        .i_cfg        (w_cfg),
        .o_item       (w_item),
        .o_bin        (w_bin)
    );

    chist_mem #(.NUM_BINS(NUM_BINS)) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_adv),
        .i_rd_addr  (w_bin),
        .o_rd_hits  (w_rd_hits),
        .o_rd_sum   (w_rd_sum),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_hits  (w_wr_hits),
        .i_wr_sum   (w_wr_sum),
        .o_clearing (w_clearing)
    );

    chist_acc #(.NUM_BINS(NUM_BINS)) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_item      (w_item),
        .i_bin       (w_bin),
        .i_rd_hits   (w_rd_hits),
        .i_rd_sum    (w_rd_sum),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_hits   (w_wr_hits),
        .o_wr_sum    (w_wr_sum),
        .o_out_valid (o_m_tvalid),
        .o_result    (w_result)
    );

endmodule

// ----- rtl/core/chist_cfg.sv -----
// Configuration register file with an APB-style slave port.
// Depends on chist_pkg for the register layout, reset values and index codes.
module chist_cfg
    import chist_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min     <= RangeMinReset;
            r_cfg.range_max     <= RangeMaxReset;
            r_cfg.bins_per_unit <= BinsPerUnitReset;
            r_cfg.bins_used     <= BinsUsedReset;
        end else if (w_wr) begin
            unique case (w_idx)
                RegRangeMin:    r_cfg.range_min     <= pwdata;
                RegRangeMax:    r_cfg.range_max     <= pwdata;
                RegBinsPerUnit: r_cfg.bins_per_unit <= pwdata;
                RegBinsUsed:    r_cfg.bins_used     <= pwdata[UsedW-1:0];
                default:        r_cfg.bins_used     <= r_cfg.bins_used;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            RegRangeMin:    prdata = r_cfg.range_min;
            RegRangeMax:    prdata = r_cfg.range_max;
            RegBinsPerUnit: prdata = r_cfg.bins_per_unit;
            RegBinsUsed:    prdata = {{(32-UsedW){1'b0}}, r_cfg.bins_used};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/chist_bin.sv -----
// Bin selection front end: input register, offset subtract, reciprocal multiply, clamp.
// Depends on chist_pkg for the configuration and pipeline item types.
module chist_bin
    import chist_pkg::*;
#(
    parameter int NUM_BINS = NumBinsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic                        i_req_type,
    input  logic signed [SampleW-1:0]   i_sample,
    input  logic [SelW-1:0]             i_bin_select,
    input  t_cfg                        i_cfg,
    output t_item                       o_item,
    output logic [$clog2(NUM_BINS)-1:0] o_bin
);

    localparam int BinW = $clog2(NUM_BINS);
    localparam int CntW = ($clog2(NUM_BINS + 1) > UsedW) ? $clog2(NUM_BINS + 1) : UsedW;

    // Stage 0: captured request.
    logic                      r0_valid;
    logic                      r0_is_add;
    logic signed [SampleW-1:0] r0_sample;
    logic [SelW-1:0]           r0_sel;
    // Stage 1: offset from the lower range edge, exact in 33 bits.
    logic                      r1_valid;
    logic                      r1_is_add;
    logic signed [SampleW-1:0] r1_sample;
    logic [SelW-1:0]           r1_sel;
    logic signed [SampleW:0]   r1_diff;
    // Stage 2: integer part of the scaled offset.
    logic                      r2_valid;
    logic                      r2_is_add;
    logic signed [SampleW-1:0] r2_sample;
    logic [SelW-1:0]           r2_sel;
    logic                      r2_neg;
    logic [31:0]               r2_prod_hi;

    logic signed [SampleW:0] n1_diff;
    logic [63:0]             n2_prod;
    logic [CntW-1:0]         w_used;
    logic [CntW-1:0]         w_num;
    logic [CntW-1:0]         w_eff;
    logic [CntW-1:0]         w_top;
    logic [BinW-1:0]         w_add_bin;

    assign n1_diff = {r0_sample[SampleW-1], r0_sample}
                   - {i_cfg.range_min[SampleW-1], i_cfg.range_min};
    // A non-negative offset is below 2^32, so only its low 32 bits reach the multiplier.
    assign n2_prod = 64'(r1_diff[SampleW-1:0]) * 64'(i_cfg.bins_per_unit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_is_add  <= (i_req_type == ReqAdd);
            r0_sample  <= i_sample;
            r0_sel     <= i_bin_select;
            r1_is_add  <= r0_is_add;
            r1_sample  <= r0_sample;
            r1_sel     <= r0_sel;
            r1_diff    <= n1_diff;
            r2_is_add  <= r1_is_add;
            r2_sample  <= r1_sample;
            r2_sel     <= r1_sel;
            r2_neg     <= r1_diff[SampleW];
            r2_prod_hi <= n2_prod[63:32];
        end
    end

    // Bins in use, forced into 1..NUM_BINS.
    assign w_used = CntW'(i_cfg.bins_used);
    assign w_num  = CntW'(NUM_BINS);
    always_comb begin
        priority if (w_used == '0) begin
            w_eff = CntW'(1);
        end else if (w_used > w_num) begin
            w_eff = w_num;
        end else begin
            w_eff = w_used;
        end
    end
    assign w_top = w_eff - CntW'(1);

    always_comb begin
        priority if (r2_neg) begin
            w_add_bin = '0;
        end else if (r2_prod_hi > 32'(w_top)) begin
            w_add_bin = BinW'(w_top);
        end else begin
            w_add_bin = BinW'(r2_prod_hi);
        end
    end

    always_comb begin
        o_item.valid  = r2_valid;
        o_item.is_add = r2_is_add;
        o_item.sel    = r2_sel;
        o_item.sample = r2_sample;
        if (r2_is_add) begin
            o_item.zero = 1'b0;
            o_bin       = w_add_bin;
        end else begin
            // A read at or beyond the bins in use shows zero.
            o_item.zero = (CntW'(r2_sel) >= w_eff);
            o_bin       = BinW'(r2_sel);
        end
    end

endmodule

// ----- rtl/core/chist_mem.sv -----
// Bin storage: hit count and sum per bin, one write and one registered read port.
// Depends on chist_pkg for widths; clears itself one entry per cycle after reset.
module chist_mem
    import chist_pkg::*;
#(
    parameter int NUM_BINS = NumBinsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(NUM_BINS)-1:0] i_rd_addr,
    output logic [HitsW-1:0]            o_rd_hits,
    output logic signed [SumW-1:0]      o_rd_sum,
    input  logic                        i_wr_en,
    input  logic [$clog2(NUM_BINS)-1:0] i_wr_addr,
    input  logic [HitsW-1:0]            i_wr_hits,
    input  logic signed [SumW-1:0]      i_wr_sum,
    output logic                        o_clearing
);

    localparam int BinW = $clog2(NUM_BINS);

    logic [HitsW+SumW-1:0] r_mem [NUM_BINS];
    logic [HitsW+SumW-1:0] r_rd;
    logic                  r_clearing;
    logic [BinW-1:0]       r_clr_addr;

    logic                  w_we;
    logic [BinW-1:0]       w_addr;
    logic [HitsW+SumW-1:0] w_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + BinW'(1);
            if (r_clr_addr == BinW'(NUM_BINS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign w_we   = r_clearing || i_wr_en;
    assign w_addr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_data = r_clearing ? '0 : {i_wr_hits, i_wr_sum};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_hits  = r_rd[HitsW+SumW-1:SumW];
    assign o_rd_sum   = r_rd[SumW-1:0];
    assign o_clearing = r_clearing;

endmodule

// ----- rtl/core/chist_acc.sv -----
// Bin update stage with write forwarding, the global trackers and the result register.
// Depends on chist_pkg for the item and result types; the saturation limits are local.
module chist_acc
    import chist_pkg::*;
#(
    parameter int NUM_BINS = NumBinsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  t_item                       i_item,
    input  logic [$clog2(NUM_BINS)-1:0] i_bin,
    input  logic [HitsW-1:0]            i_rd_hits,
    input  logic signed [SumW-1:0]      i_rd_sum,
    output logic                        o_wr_en,
    output logic [$clog2(NUM_BINS)-1:0] o_wr_addr,
    output logic [HitsW-1:0]            o_wr_hits,
    output logic signed [SumW-1:0]      o_wr_sum,
    output logic                        o_out_valid,
    output t_result                     o_result
);

    localparam int BinW = $clog2(NUM_BINS);
    localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

    function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                                input logic [SampleW-1:0] b);
        logic [SumW:0] s;
        s = {a[SumW-1], a} + {{(SumW-SampleW+1){b[SampleW-1]}}, b};
        if (s[SumW] != s[SumW-1]) begin
            return s[SumW] ? SumMin : SumMax;
        end
        return s[SumW-1:0];
    endfunction

    t_item                     r_b;
    logic [BinW-1:0]           r_b_bin;
    logic                      r_fwd;
    logic [HitsW-1:0]          r_fwd_hits;
    logic signed [SumW-1:0]    r_fwd_sum;
    logic signed [SampleW-1:0] r_low;
    logic signed [SampleW-1:0] r_high;
    logic signed [SumW-1:0]    r_total;
    logic [SampleW-1:0]        r_count;
    logic                      r_out_valid;
    t_result                   r_out;

    logic signed [SampleW-1:0] w_sample;
    logic                      w_do_add;
    logic [HitsW-1:0]          w_old_hits;
    logic signed [SumW-1:0]    w_old_sum;
    logic [HitsW-1:0]          w_new_hits;
    logic signed [SumW-1:0]    w_new_sum;
    logic signed [SampleW-1:0] n_low;
    logic signed [SampleW-1:0] n_high;
    logic signed [SumW-1:0]    n_total;
    logic [SampleW-1:0]        n_count;
    t_result                   n_out;

    assign w_sample = r_b.sample;
    assign w_do_add = r_b.valid && r_b.is_add;

    // The item ahead wrote its bin at the same edge this one read it, so take its value.
    assign w_old_hits = r_fwd ? r_fwd_hits : i_rd_hits;
    assign w_old_sum  = r_fwd ? r_fwd_sum : i_rd_sum;
    assign w_new_hits = (&w_old_hits) ? w_old_hits : w_old_hits + HitsW'(1);
    assign w_new_sum  = sat_add(w_old_sum, w_sample);

    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_total = r_total;
        n_count = r_count;
        if (w_do_add) begin
            if (w_sample < r_low) begin
                n_low = w_sample;
            end
            if (w_sample > r_high) begin
                n_high = w_sample;
            end
            n_total = sat_add(r_total, w_sample);
            n_count = (&r_count) ? r_count : r_count + SampleW'(1);
        end
    end

    always_comb begin
        // A read reports the bin it asked for, even one the memory cannot hold.
        n_out.bin_index    = r_b.is_add ? IdxW'(r_b_bin) : r_b.sel;
        n_out.low_seen     = n_low;
        n_out.high_seen    = n_high;
        n_out.grand_total  = n_total;
        n_out.samples_seen = n_count;
        priority if (r_b.is_add) begin
            n_out.bin_hits  = w_new_hits;
            n_out.bin_total = w_new_sum;
        end else if (r_b.zero) begin
            n_out.bin_hits  = '0;
            n_out.bin_total = '0;
        end else begin
            n_out.bin_hits  = w_old_hits;
            n_out.bin_total = w_old_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid   <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_low       <= RangeMaxReset;
            r_high      <= RangeMinReset;
            r_total     <= '0;
            r_count     <= '0;
        end else if (i_adv) begin
            r_b         <= i_item;
            r_fwd       <= w_do_add && (r_b_bin == i_bin);
            r_out_valid <= r_b.valid;
            r_low       <= n_low;
            r_high      <= n_high;
            r_total     <= n_total;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_bin    <= i_bin;
            r_fwd_hits <= w_new_hits;
            r_fwd_sum  <= w_new_sum;
            r_out      <= n_out;
        end
    end

    assign o_wr_en     = i_adv && w_do_add;
    assign o_wr_addr   = r_b_bin;
    assign o_wr_hits   = w_new_hits;
    assign o_wr_sum    = w_new_sum;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Once a sample has been counted it lies between the two trackers.
    a_low_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_low <= r_high))
        else $error("lowest tracker above highest tracker");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_do_add && !(&r_count)) |=> (r_count == $past(r_count) + SampleW'(1)))
        else $error("sample counter did not advance on an add");

    a_read_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_b.valid && !r_b.is_add) |=>
            (r_total == $past(r_total) && r_count == $past(r_count)))
        else $error("a bin read changed the running totals");

    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (i_adv && r_b.valid))
        else $error("bin written without the stage advancing");

endmodule

// ----- sim/tb_clamped_histogram_accumulator_top.sv -----
// Self-checking testbench for clamped_histogram_accumulator_top: random add and read requests
// are checked against an in-bench histogram predictor over several register settings.
// Depends on chist_pkg and the block's RTL only.
module tb_clamped_histogram_accumulator_top
    import chist_pkg::*;
;

    localparam int BinCount   = NumBinsDefault;
    localparam int CycleLimit = 400000;
    localparam int MaxReports = 10;

    typedef struct {
        logic                      kind;
        logic signed [SampleW-1:0] smp;
        logic        [SelW-1:0]    sel;
    } t_hist_req;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [39:0]  i_s_tdata;  // sample [31:0], bin_select [37:32], zero [39:38]
    logic         i_s_tuser;  // req_type [0]
    logic         o_m_tvalid;
    logic         i_m_tready;
    // bin_index [5:0], bin_hits [37:6], bin_total [101:38], low_seen [133:102],
    // high_seen [165:134], grand_total [229:166], samples_seen [261:230], zero [263:262]
    logic [263:0] o_m_tdata;

    clamped_histogram_accumulator_top #(.NUM_BINS(BinCount)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Predictor copy of the configuration and of the histogram state.
    logic signed [SampleW-1:0] cfg_range_min   = RangeMinReset;
    logic signed [SampleW-1:0] cfg_range_max   = RangeMaxReset;
    logic        [31:0]        cfg_bins_per_unit = BinsPerUnitReset;
    logic        [UsedW-1:0]   cfg_bins_used   = BinsUsedReset;

    logic        [HitsW-1:0]   hit_tab [BinCount];
    logic signed [SumW-1:0]    sum_tab [BinCount];
    logic signed [SampleW-1:0] low_trk   = RangeMaxReset;
    logic signed [SampleW-1:0] high_trk  = RangeMinReset;
    logic signed [SumW-1:0]    total_acc = '0;
    logic        [HitsW-1:0]   count_acc = '0;

    t_hist_req pending_reqs[$];
    t_result   bin_reports[$];
    int        outstanding = 0;
    int        mismatches  = 0;
    int        cycles      = 0;
    logic      req_fire    = 1'b0;
    logic      res_fire    = 1'b0;
    logic      no_gaps     = 1'b0;
    int        req_gap     = 0;
    int        res_stall   = 0;

    initial begin
        for (int b = 0; b < BinCount; b++) begin
            hit_tab[b] = '0;
            sum_tab[b] = '0;
        end
    end

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [HitsW-1:0] sat_inc(input logic [HitsW-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW-1:0] a,
                                                       input logic signed [SampleW-1:0] s);
        logic [SumW:0] w;
        w = {a[SumW-1], a} + {{(SumW-SampleW+1){s[SampleW-1]}}, s};
        if (w[SumW] != w[SumW-1])
            return w[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        return w[SumW-1:0];
    endfunction

    // Applies one request to the predicted histogram and forms the expected result.
    task automatic bin_update(input logic kind, input logic signed [SampleW-1:0] smp,
                              input logic [SelW-1:0] sel, output t_result r);
        logic [SampleW:0] d;
        logic [63:0]      prod;
        logic [31:0]      raw_bin;
        int               eff;
        int               idx;
        eff = (cfg_bins_used == 0) ? 1 : ((cfg_bins_used > BinCount) ? BinCount : cfg_bins_used);
        r = '0;
        if (kind == ReqAdd) begin
            d = {smp[SampleW-1], smp} - {cfg_range_min[SampleW-1], cfg_range_min};
            if (d[SampleW]) begin
                idx = 0;
            end else begin
                prod    = 64'(d[SampleW-1:0]) * 64'(cfg_bins_per_unit);
                raw_bin = prod[63:32];
                idx     = (raw_bin > eff - 1) ? eff - 1 : int'(raw_bin);
            end
            hit_tab[idx] = sat_inc(hit_tab[idx]);
            sum_tab[idx] = sat_sum(sum_tab[idx], smp);
            if (smp < low_trk)
                low_trk = smp;
            if (smp > high_trk)
                high_trk = smp;
            total_acc   = sat_sum(total_acc, smp);
            count_acc   = sat_inc(count_acc);
            r.bin_hits  = hit_tab[idx];
            r.bin_total = sum_tab[idx];
        end else begin
            idx = sel;
            // Bins past the ones in use read back as empty.
            if (idx < eff) begin
                r.bin_hits  = hit_tab[idx];
                r.bin_total = sum_tab[idx];
            end
        end
        r.bin_index    = idx[IdxW-1:0];
        r.low_seen     = low_trk;
        r.high_seen    = high_trk;
        r.grand_total  = total_acc;
        r.samples_seen = count_acc;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (mismatches < MaxReports)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_req(input logic kind, input logic [31:0] smp, input logic [5:0] sel);
        t_hist_req q;
        q.kind = kind;
        q.smp  = smp;
        q.sel  = sel;
        pending_reqs.push_back(q);
        outstanding++;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            RegRangeMin:    cfg_range_min     = val;
            RegRangeMax:    cfg_range_max     = val;
            RegBinsPerUnit: cfg_bins_per_unit = val;
            RegBinsUsed:    cfg_bins_used     = val[UsedW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (outstanding > 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] rmin, input logic [31:0] rmax,
                             input logic [31:0] bpu, input logic [6:0] used, input int n);
        logic        kind;
        logic [31:0] smp;
        logic [5:0]  sel;
        int          top;
        reg_write(RegRangeMin, rmin);
        reg_write(RegRangeMax, rmax);
        reg_write(RegBinsPerUnit, bpu);
        // Upper bits beyond the register width are written as noise.
        reg_write(RegBinsUsed, {25'($urandom_range(0, 33554431)), used});
        top = (used == 0) ? 0 : ((used > BinCount) ? BinCount - 1 : used - 1);
        for (int k = 0; k < n; k++) begin
            kind = ($urandom_range(0, 9) < 7) ? ReqAdd : ReqRead;
            case ($urandom_range(0, 7))
                0: smp = $urandom;
                1: smp = 32'h8000_0000;
                2: smp = 32'h7FFF_FFFF;
                3: smp = rmin - 1;
                default: smp = rmin + ($urandom >> $urandom_range(0, 31));
            endcase
            sel = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, top));
            queue_req(kind, smp, sel);
        end
        wait_idle();
    endtask

    // Request driver: one transaction at a time with a random gap before each unless no_gaps is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= 1'b0;
            req_gap     = no_gaps ? 0 : $urandom_range(0, 19);
        end else if (!i_s_tvalid || req_fire) begin
            if (req_fire)
                req_gap = no_gaps ? 0 : $urandom_range(0, 19);
            if (req_gap != 0 || pending_reqs.size() == 0) begin
                if (req_gap != 0)
                    req_gap--;
                i_s_tvalid <= 1'b0;
            end else begin
                t_hist_req q;
                q = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {2'b00, q.sel, q.smp};
                i_s_tuser  <= q.kind;
            end
        end
    end

    // Result side back-pressure: a random stall after each transaction unless no_gaps is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            res_stall   = 0;
        end else begin
            if (res_fire)
                res_stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (res_stall != 0) begin
                res_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted request, then checks each accepted result.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        req_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        res_fire <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            bin_update(i_s_tuser, i_s_tdata[31:0], i_s_tdata[37:32], want);
            bin_reports.push_back(want);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[261:0];
            if (bin_reports.size() == 0) begin
                if (mismatches < MaxReports)
                    $display("mismatch: result with no request waiting, got %h", o_m_tdata);
                mismatches++;
            end else begin
                want = bin_reports.pop_front();
                outstanding--;
                check_field("bin_index", want.bin_index, got.bin_index);
                check_field("bin_hits", want.bin_hits, got.bin_hits);
                check_field("bin_total", want.bin_total, got.bin_total);
                check_field("low_seen", want.low_seen, got.low_seen);
                check_field("high_seen", want.high_seen, got.high_seen);
                check_field("grand_total", want.grand_total, got.grand_total);
                check_field("samples_seen", want.samples_seen, got.samples_seen);
                check_field("padding", 64'd0, o_m_tdata[263:262]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings: empty reads, field extremes,
        // the edges of the range and a read with stray sample bits.
        queue_req(ReqRead, 32'h0000_0000, 6'd0);
        queue_req(ReqRead, 32'hFFFF_FFFF, 6'd63);
        queue_req(ReqAdd,  32'h0000_0000, 6'd0);
        queue_req(ReqAdd,  32'h7FFF_FFFF, 6'd0);
        queue_req(ReqAdd,  32'h8000_0000, 6'd63);
        queue_req(ReqAdd,  32'hFFFF_FFFF, 6'd21);
        queue_req(ReqAdd,  32'd6553599,   6'd0);
        queue_req(ReqAdd,  32'd6553600,   6'd0);
        queue_req(ReqAdd,  32'd102400,    6'd0);
        queue_req(ReqAdd,  32'h0001_0000, 6'd0);
        queue_req(ReqAdd,  32'd5,         6'd63);
        queue_req(ReqRead, 32'h7FFF_FFFF, 6'd0);
        queue_req(ReqRead, 32'h0000_0000, 6'd1);
        queue_req(ReqRead, 32'h0000_0000, 6'd63);
        queue_req(ReqRead, 32'h8000_0000, 6'h2A);
        queue_req(ReqRead, 32'h0000_0000, 6'd62);
        wait_idle();

        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd64, 7'd64, 200);
        no_gaps = 1'b1;
        // Bins in use of zero falls back to a single bin.
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 7'd0, 80);
        no_gaps = 1'b0;
        run_phase(-32'sd655360, 32'd655360, 32'h0003_0000, 7'd127, 200);
        // Zero bins per unit sends every sample to the first bin.
        run_phase(32'h0000_0000, 32'h0064_0000, 32'h0000_0000, 7'd1, 80);
        run_phase($urandom, $urandom, $urandom, 7'($urandom_range(0, 127)), 200);
        no_gaps = 1'b1;
        run_phase(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 7'd64, 120);
        no_gaps = 1'b0;
        run_phase(32'h0000_0000, 32'h0040_0000, 32'h0001_0000, 7'd65, 170);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/chist_pkg.sv
rtl/core/chist_cfg.sv
rtl/core/chist_bin.sv
rtl/core/chist_mem.sv
rtl/core/chist_acc.sv
rtl/core/clamped_histogram_accumulator_top.sv
sim/tb_clamped_histogram_accumulator_top.sv
